### rtl/core/pump_runtime_alarm_monitor_core_assert.svh
// Assertion macros used by the pump runtime alarm monitor checker.
`ifndef PUMP_RUNTIME_ALARM_MONITOR_CORE_ASSERT_SVH
`define PUMP_RUNTIME_ALARM_MONITOR_CORE_ASSERT_SVH

// Checked only outside reset.
`define PRAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define PRAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/pram_pkg.sv
// Types, constants and codes of the pump runtime alarm monitor.
package pram_pkg;

  localparam int unsigned RUN_SLOTS  = 4;
  // Only an even number of slots is used so even/odd keeps its off/on meaning.
  localparam int unsigned USED_SLOTS = (RUN_SLOTS / 2) * 2;
  localparam int unsigned SLOT_W     = $clog2(USED_SLOTS);

  localparam int unsigned RUN_W      = 24;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned SAMPLE_W   = 2;
  localparam int unsigned CAUSE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [RUN_W-1:0]      run_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam slot_t LAST_SLOT = slot_t'(USED_SLOTS - 1);
  localparam run_t  RUN_MAX   = '1;
  localparam cnt_t  CNT_MAX   = '1;

  // Pump sample codes; other codes leave the runs alone.
  localparam sample_t SAMPLE_OFF = 2'd0;
  localparam sample_t SAMPLE_ON  = 2'd1;

  // Register indexes.
  localparam cfg_idx_t REG_ON_LONG   = 3'd0;
  localparam cfg_idx_t REG_ON_CHECK  = 3'd1;
  localparam cfg_idx_t REG_OFF_LONG  = 3'd2;
  localparam cfg_idx_t REG_OFF_HIGH  = 3'd3;
  localparam cfg_idx_t REG_CRITICAL  = 3'd4;

  // Register reset values.
  localparam run_t   ON_LONG_RST   = run_t'(60);
  localparam run_t   ON_CHECK_RST  = run_t'(60);
  localparam run_t   OFF_LONG_RST  = run_t'(86400);
  localparam run_t   OFF_HIGH_RST  = run_t'(86400);
  localparam level_t CRITICAL_RST  = level_t'(400);

  localparam cnt_t RISE_CNT_RST    = cnt_t'(5);

  // Counter thresholds (strictly greater than).
  localparam cnt_t HIGH_OFF_MIN    = cnt_t'(2);
  localparam cnt_t HIGH_RUN_MIN    = cnt_t'(3);
  localparam cnt_t RISE_MIN        = cnt_t'(2);

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_OK       = 3'd0,
    CAUSE_OFF_LONG = 3'd1,
    CAUSE_OFF_HIGH = 3'd2,
    CAUSE_RISING   = 3'd3,
    CAUSE_ON_LONG  = 3'd4,
    CAUSE_HIGH_RUN = 3'd5
  } cause_e;

endpackage

### rtl/core/pram_if.sv
// Sample, result and register write channels of the pump runtime alarm monitor.
interface pram_in_if;
  logic                  valid;
  logic                  ready;
  pram_pkg::sample_t     pump_sample;
  pram_pkg::level_t      water_level;

  modport source (output valid, output pump_sample, output water_level, input ready);
  modport sink   (input valid, input pump_sample, input water_level, output ready);
endinterface

interface pram_out_if;
  logic                          valid;
  logic                          ready;
  logic                          alarm;
  logic [pram_pkg::CAUSE_W-1:0]  cause;
  logic                          pump_running;
  pram_pkg::run_t                run_length;

  modport source (output valid, output alarm, output cause, output pump_running,
                  output run_length, input ready);
  modport sink   (input valid, input alarm, input cause, input pump_running,
                  input run_length, output ready);
endinterface

interface pram_cfg_if;
  logic                  valid;
  logic                  ready;
  pram_pkg::cfg_idx_t    index;
  pram_pkg::cfg_data_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/pump_runtime_alarm_monitor_core.sv
// Top level of the pump runtime alarm monitor.
// One sample item is taken per clock while the result side does not stall, and
// one result item comes out for each: the item is held in the input register,
// then the run, level and rise updates and the alarm decode settle in one pass
// into the result register. The output register lets the next item enter while
// a result waits. Only the open run's length is kept, since a new slot always
// starts at one and older slots are never read back. Register writes take
// effect on the next item and are accepted every cycle.
module pump_runtime_alarm_monitor_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  pram_in_if.sink    in_i,
  pram_out_if.source out_o,
  pram_cfg_if.sink   cfg_i
);

  // Configuration registers
  pram_pkg::run_t   on_long_q, on_check_q, off_long_q, off_high_q;
  pram_pkg::level_t critical_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_long_q  <= pram_pkg::ON_LONG_RST;
      on_check_q <= pram_pkg::ON_CHECK_RST;
      off_long_q <= pram_pkg::OFF_LONG_RST;
      off_high_q <= pram_pkg::OFF_HIGH_RST;
      critical_q <= pram_pkg::CRITICAL_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pram_pkg::REG_ON_LONG:  on_long_q  <= cfg_i.data;
        pram_pkg::REG_ON_CHECK: on_check_q <= cfg_i.data;
        pram_pkg::REG_OFF_LONG: off_long_q <= cfg_i.data;
        pram_pkg::REG_OFF_HIGH: off_high_q <= cfg_i.data;
        pram_pkg::REG_CRITICAL: critical_q <= cfg_i.data[pram_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                s1_valid_q;
  pram_pkg::sample_t   s1_sample_q;
  pram_pkg::level_t    s1_level_q;
  logic                out_valid_q;
  logic                out_free;
  logic                step;
  logic                in_take;

  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_sample_q <= in_i.pump_sample;
      s1_level_q  <= in_i.water_level;
    end
  end

  // Monitor state
  pram_pkg::slot_t  slot_q, slot_d;
  pram_pkg::run_t   run_q, run_d, run_inc;
  pram_pkg::cnt_t   high_q, high_d, rise_q, rise_d;
  pram_pkg::level_t prev_level_q;
  logic             prev_valid_q;
  pram_pkg::cause_e cause_d;
  logic             on_d;

  assign run_inc = (run_q == pram_pkg::RUN_MAX) ? run_q : run_q + pram_pkg::run_t'(1);

  always_comb begin
    slot_d = slot_q;
    run_d  = run_q;
    case (s1_sample_q)
      pram_pkg::SAMPLE_OFF: begin
        if (slot_q[0]) begin
          slot_d = (slot_q == pram_pkg::LAST_SLOT) ? '0 : slot_q + pram_pkg::slot_t'(1);
          run_d  = pram_pkg::run_t'(1);
        end else begin
          run_d = run_inc;
        end
      end
      pram_pkg::SAMPLE_ON: begin
        if (!slot_q[0]) begin
          slot_d = slot_q + pram_pkg::slot_t'(1);
          run_d  = pram_pkg::run_t'(1);
        end else begin
          run_d = run_inc;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (s1_level_q > critical_q) begin
      high_d = (high_q == pram_pkg::CNT_MAX) ? high_q : high_q + pram_pkg::cnt_t'(1);
    end else begin
      high_d = '0;
    end
    // first sample after reset never counts as a rise
    if (prev_valid_q && (s1_level_q > prev_level_q)) begin
      rise_d = (rise_q == pram_pkg::CNT_MAX) ? rise_q : rise_q + pram_pkg::cnt_t'(1);
    end else begin
      rise_d = '0;
    end
  end

  assign on_d = slot_d[0];

  always_comb begin
    cause_d = pram_pkg::CAUSE_OK;
    if (!on_d) begin
      if (run_d > off_long_q) begin
        cause_d = pram_pkg::CAUSE_OFF_LONG;
      end else if ((run_d > off_high_q) && (high_d > pram_pkg::HIGH_OFF_MIN)) begin
        cause_d = pram_pkg::CAUSE_OFF_HIGH;
      end
    end else if (run_d > on_check_q) begin
      if (rise_d > pram_pkg::RISE_MIN) begin
        cause_d = pram_pkg::CAUSE_RISING;
      end else if (run_d > on_long_q) begin
        cause_d = pram_pkg::CAUSE_ON_LONG;
      end else if (high_d > pram_pkg::HIGH_RUN_MIN) begin
        cause_d = pram_pkg::CAUSE_HIGH_RUN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q       <= '0;
      run_q        <= '0;
      high_q       <= '0;
      rise_q       <= pram_pkg::RISE_CNT_RST;
      prev_level_q <= '0;
      prev_valid_q <= 1'b0;
    end else if (step) begin
      slot_q       <= slot_d;
      run_q        <= run_d;
      high_q       <= high_d;
      rise_q       <= rise_d;
      prev_level_q <= s1_level_q;
      prev_valid_q <= 1'b1;
    end
  end

  // Result register
  logic             alarm_q;
  pram_pkg::cause_e cause_q;
  logic             running_q;
  pram_pkg::run_t   run_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      alarm_q   <= (cause_d != pram_pkg::CAUSE_OK);
      cause_q   <= cause_d;
      running_q <= on_d;
      run_out_q <= run_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.alarm        = alarm_q;
  assign out_o.cause        = cause_q;
  assign out_o.pump_running = running_q;
  assign out_o.run_length   = run_out_q;

endmodule

### rtl/core/pram_checker.sv
// Port-level checks of the pump runtime alarm monitor, bound to the top level.
`include "pump_runtime_alarm_monitor_core_assert.svh"

module pram_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          alarm_i,
  input logic [pram_pkg::CAUSE_W-1:0]  cause_i,
  input logic                          running_i
);

  logic cause_ok;
  logic off_cause;
  logic on_cause;

  assign cause_ok  = (cause_i == pram_pkg::CAUSE_OK);
  assign off_cause = (cause_i == pram_pkg::CAUSE_OFF_LONG) ||
                     (cause_i == pram_pkg::CAUSE_OFF_HIGH);
  assign on_cause  = (cause_i == pram_pkg::CAUSE_RISING) ||
                     (cause_i == pram_pkg::CAUSE_ON_LONG) ||
                     (cause_i == pram_pkg::CAUSE_HIGH_RUN);

  `PRAM_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_i, "result shown in reset")

  `PRAM_ASSERT(a_result_holds, (out_valid_i && !out_ready_i) |=> out_valid_i, "result dropped")

  `PRAM_ASSERT(a_alarm_matches_cause, out_valid_i |-> (alarm_i == !cause_ok), "alarm/cause mismatch")

  `PRAM_ASSERT(a_off_cause_when_off, (out_valid_i && off_cause) |-> !running_i, "off cause on an on run")

  `PRAM_ASSERT(a_on_cause_when_on, (out_valid_i && on_cause) |-> running_i, "on cause on an off run")

endmodule

bind pump_runtime_alarm_monitor_core pram_checker u_pram_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .alarm_i     (out_o.alarm),
  .cause_i     (out_o.cause),
  .running_i   (out_o.pump_running)
);
